// ----- src/shabs_pkg.sv -----
// shared types and constants for the sha-256 byte stream hasher
// round constants, initial hash words, sequencer states, round variable bundle
// no dependencies
package shabs_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_OUT
	} shabs_state_t;

	// working variables a..h of one compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} shabs_vars_t;

	// sixteen-word message schedule window, [15] is the oldest word
	typedef logic [15:0][31:0] shabs_window_t;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] INITIAL_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- src/shabs_round.sv -----
// one sha-256 round and one message schedule step, combinational
// shared by every round of every block under the top level sequencer
// depends on shabs_pkg
module shabs_round (
	input  shabs_pkg::shabs_vars_t   vars,
	input  shabs_pkg::shabs_window_t win,
	input  logic [31:0]              k,
	output shabs_pkg::shabs_vars_t   vars_next,
	output logic [31:0]              sched_word
);

	logic [31:0] w;
	logic [31:0] big_s1;
	logic [31:0] big_s0;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] small_s0;
	logic [31:0] small_s1;

	// round function on the oldest window word
	assign w = win[15];
	assign big_s1 = shabs_pkg::rotr(vars.e, 6) ^ shabs_pkg::rotr(vars.e, 11)
		^ shabs_pkg::rotr(vars.e, 25);
	assign big_s0 = shabs_pkg::rotr(vars.a, 2) ^ shabs_pkg::rotr(vars.a, 13)
		^ shabs_pkg::rotr(vars.a, 22);
	assign ch = (vars.e & vars.f) ^ (~vars.e & vars.g);
	assign maj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
	assign t1 = vars.h + big_s1 + ch + k + w;
	assign t2 = big_s0 + maj;

	always_comb begin
		vars_next.h = vars.g;
		vars_next.g = vars.f;
		vars_next.f = vars.e;
		vars_next.e = vars.d + t1;
		vars_next.d = vars.c;
		vars_next.c = vars.b;
		vars_next.b = vars.a;
		vars_next.a = t1 + t2;
	end

	// next schedule word from taps t+1, t+9, t+14 and t
	assign small_s0 = shabs_pkg::rotr(win[14], 7) ^ shabs_pkg::rotr(win[14], 18)
		^ (win[14] >> 3);
	assign small_s1 = shabs_pkg::rotr(win[1], 17) ^ shabs_pkg::rotr(win[1], 19)
		^ (win[1] >> 10);
	assign sched_word = small_s1 + win[6] + small_s0 + win[15];

endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
// sha-256 over a byte stream: byte input, eight digest words out
// one shared round unit under a five-state sequencer
// depends on shabs_pkg and shabs_round
//
// usage
//   input stream: one message byte per word on s_tdata, s_tlast high on the
//   last byte of a message. empty messages are not supported.
//   output stream: eight 32-bit digest words h0..h7 on m_tdata, m_tlast on h7.
// sequence
//   a byte that does not complete a 64-byte block is shifted in and counted.
//   a byte that completes a block loads the working variables, then the block
//   runs the 64 rounds through the one round unit and folds the result into
//   the chaining words. after the last byte the padding bytes go into the block
//   one per cycle (up to 72 when the length spills into an extra block, each
//   full block again rounded and folded), then the eight digest words are
//   offered, one per cycle while m_tready holds.
//   s_tready is low from the last byte until the eighth digest word is taken.
// reset
//   arst_n clears the sequencer, the byte count and loads the initial hash words.
//   after the eighth digest word the block is back in that state.
// stall
//   a low m_tready holds the current digest word and the block waits.
module sha256_byte_stream_hasher #(
	parameter int LENGTH_COUNTER_BITS = 61
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast    // digest_last
);

	shabs_pkg::shabs_state_t  state_q;
	shabs_pkg::shabs_state_t  next_state;
	shabs_pkg::shabs_state_t  after_q;
	shabs_pkg::shabs_window_t win_q;
	shabs_pkg::shabs_vars_t   vars_q;
	shabs_pkg::shabs_vars_t   vars_next;
	logic [31:0]              sched_word;
	logic [31:0]              chain_q [8];
	logic [LENGTH_COUNTER_BITS-1:0] count_q;
	logic [5:0]               pos_q;
	logic [5:0]               rnd_q;
	logic [2:0]               out_idx_q;
	logic                     marker_q;
	logic                     extra_q;

	logic        in_accept;
	logic        out_accept;
	logic        pad_push;
	logic        round_en;
	logic        fold_en;
	logic        push;
	logic        block_full;
	logic [7:0]  push_byte;
	logic [7:0]  pad_byte;
	logic [63:0] len_bits;

	// shared round unit
	shabs_round u_round (
		.vars       (vars_q),
		.win        (win_q),
		.k          (shabs_pkg::ROUND_K[rnd_q]),
		.vars_next  (vars_next),
		.sched_word (sched_word)
	);

	// next state
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			shabs_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (pos_q == shabs_pkg::LAST_POS) next_state = shabs_pkg::ST_ROUND;
					else if (s_tlast) next_state = shabs_pkg::ST_PAD;
				end
			end
			shabs_pkg::ST_ROUND: begin
				if (rnd_q == shabs_pkg::LAST_ROUND) next_state = shabs_pkg::ST_FOLD;
			end
			shabs_pkg::ST_FOLD: next_state = after_q;
			shabs_pkg::ST_PAD: begin
				if (pos_q == shabs_pkg::LAST_POS) next_state = shabs_pkg::ST_ROUND;
			end
			shabs_pkg::ST_OUT: begin
				if (m_tready && out_idx_q == shabs_pkg::LAST_WORD)
					next_state = shabs_pkg::ST_IDLE;
			end
			default: next_state = shabs_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		pad_push = 1'b0;
		round_en = 1'b0;
		fold_en  = 1'b0;
		unique case (state_q)
			shabs_pkg::ST_IDLE:  s_tready = 1'b1;
			shabs_pkg::ST_ROUND: round_en = 1'b1;
			shabs_pkg::ST_FOLD:  fold_en  = 1'b1;
			shabs_pkg::ST_PAD:   pad_push = 1'b1;
			shabs_pkg::ST_OUT:   m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign in_accept  = s_tvalid && s_tready;
	assign out_accept = m_tvalid && m_tready;
	assign push       = in_accept || pad_push;
	assign block_full = push && (pos_q == shabs_pkg::LAST_POS);

	// padding byte: marker, zero fill, then big-endian bit length
	assign len_bits = 64'(count_q) << 3;
	always_comb begin
		if (!marker_q) pad_byte = shabs_pkg::PAD_MARK;
		else if (extra_q || pos_q < shabs_pkg::LEN_POS) pad_byte = 8'h00;
		else pad_byte = len_bits[{~pos_q[2:0], 3'b000} +: 8];
	end
	assign push_byte = pad_push ? pad_byte : s_tdata;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= shabs_pkg::ST_IDLE;
			after_q   <= shabs_pkg::ST_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			rnd_q     <= '0;
			out_idx_q <= '0;
			marker_q  <= 1'b0;
			extra_q   <= 1'b0;
		end else begin
			state_q <= next_state;
			if (push) pos_q <= pos_q + 6'd1;
			if (in_accept) count_q <= count_q + 1'b1;
			if (round_en) rnd_q <= rnd_q + 6'd1;
			// where to go once the block is folded in
			if (in_accept && block_full)
				after_q <= s_tlast ? shabs_pkg::ST_PAD : shabs_pkg::ST_IDLE;
			else if (pad_push && block_full)
				after_q <= (marker_q && !extra_q) ? shabs_pkg::ST_OUT : shabs_pkg::ST_PAD;
			// padding progress
			if (pad_push && !marker_q) begin
				marker_q <= 1'b1;
				extra_q  <= (pos_q[5:3] == 3'h7) && (pos_q != shabs_pkg::LAST_POS);
			end else if (pad_push && block_full) begin
				extra_q <= 1'b0;
			end
			// digest delivery and return to the initial state
			if (out_accept) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == shabs_pkg::LAST_WORD) begin
					count_q  <= '0;
					marker_q <= 1'b0;
					extra_q  <= 1'b0;
				end
			end
		end
	end

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (push) win_q <= {win_q[15][23:0], win_q[14:0], push_byte};
		else if (round_en) win_q <= {win_q[14:0], sched_word};
		if (block_full) begin
			vars_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3],
				e: chain_q[4], f: chain_q[5], g: chain_q[6], h: chain_q[7]};
		end else if (round_en) begin
			vars_q <= vars_next;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= shabs_pkg::INITIAL_H[i];
		end else if (fold_en) begin
			chain_q[0] <= chain_q[0] + vars_q.a;
			chain_q[1] <= chain_q[1] + vars_q.b;
			chain_q[2] <= chain_q[2] + vars_q.c;
			chain_q[3] <= chain_q[3] + vars_q.d;
			chain_q[4] <= chain_q[4] + vars_q.e;
			chain_q[5] <= chain_q[5] + vars_q.f;
			chain_q[6] <= chain_q[6] + vars_q.g;
			chain_q[7] <= chain_q[7] + vars_q.h;
		end else if (out_accept && out_idx_q == shabs_pkg::LAST_WORD) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= shabs_pkg::INITIAL_H[i];
		end
	end

	// digest word out
	assign m_tdata = chain_q[out_idx_q];
	assign m_tlast = (out_idx_q == shabs_pkg::LAST_WORD);

endmodule

// ----- src/shabs_checker.sv -----
// port-level checks for the sha-256 byte stream hasher
// bound to the top level below; depends on nothing else
module shabs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// no byte taken while digest words are offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while digest words pending");

	// a stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled digest word changed");

	// a byte without the final mark gives no digest word next
	a_no_early_digest: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
		else $error("digest word after a non-final byte");

	// final byte closes the input until the digest is out
	a_final_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after the final byte");

	// after the last digest word the block is idle and ready
	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("not idle after the last digest word");

endmodule

bind sha256_byte_stream_hasher shabs_checker u_shabs_checker (.*);

// ----- test/sha256_byte_stream_hasher_tb.sv -----
// testbench for the sha-256 byte stream hasher
// drives message bytes, predicts the digest words with its own sha-256 and checks each one
// depends on the sha256_byte_stream_hasher top level only
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;

	// sha-256 round constants and initial hash words
	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] SHA_H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam int unsigned PAD_LEN_POS = 56;
	localparam int unsigned TAIL_CYCLES = 80;
	// byte total at which the random section stops
	localparam int RANDOM_STOP = 314;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} digest_entry_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
	logic        s_tlast = 1'b0;    // final_byte
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [31:0] m_tdata;           // [31:0] digest_word
	logic        m_tlast;           // digest_last

	// predictor state
	logic [31:0] chain_h [8];
	logic [7:0]  block_buf [64];
	logic [60:0] byte_count;
	digest_entry_t expected_digest_q [$];

	bit idle_on = 1'b1;
	int errors = 0;
	int words_checked = 0;
	int bytes_sent = 0;
	int messages_sent = 0;

	sha256_byte_stream_hasher DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of block_buf into chain_h
	task automatic sha_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (int r = 0; r < 64; r++) begin
			if (r >= 16) begin
				s1 = ror32(w[(r-2)&15], 17) ^ ror32(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
				s0 = ror32(w[(r-15)&15], 7) ^ ror32(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
				w[r&15] = s1 + w[(r-7)&15] + s0 + w[r&15];
			end
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[r] + w[r&15];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endtask

	// absorb one accepted byte; on the final byte pad, finish and queue the digest
	task automatic sha_absorb(input logic [7:0] data, input logic fin);
		int p;
		logic [63:0] bit_len;
		digest_entry_t ent;
		p = byte_count[5:0];
		block_buf[p] = data;
		byte_count = byte_count + 1'b1;
		p++;
		if (p == 64) begin
			sha_compress();
			p = 0;
		end
		if (fin) begin
			block_buf[p] = 8'h80;
			p++;
			// no room for the length: zero fill and spill into an extra block
			if (p > PAD_LEN_POS) begin
				while (p < 64) begin
					block_buf[p] = 8'h00;
					p++;
				end
				sha_compress();
				p = 0;
			end
			while (p < PAD_LEN_POS) begin
				block_buf[p] = 8'h00;
				p++;
			end
			bit_len = {byte_count, 3'b000};
			for (int i = 0; i < 8; i++)
				block_buf[63-i] = bit_len[8*i +: 8];
			sha_compress();
			for (int i = 0; i < 8; i++) begin
				ent.word = chain_h[i];
				ent.last = (i == 7);
				expected_digest_q.push_back(ent);
			end
			// back to the initial state for the next message
			for (int i = 0; i < 8; i++)
				chain_h[i] = SHA_H0[i];
			byte_count = '0;
		end
	endtask

	// offer one byte, wait for the handshake, then update the prediction
	task automatic push_byte(input logic [7:0] data, input logic fin);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		sha_absorb(data, fin);
		bytes_sent++;
		if (fin)
			messages_sent++;
	endtask

	task automatic send_random_message(input int len);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// hold the sender until every queued digest word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_digest_q.size() != 0)
			@(posedge clk);
	endtask

	// single-byte messages 00, ff and 80, the short "abc" message and a two- and a four-byte message
	task automatic test_short_messages();
		push_byte(8'h00, 1'b1);
		wait_drained();
		push_byte(8'hff, 1'b1);
		wait_drained();
		push_byte(8'h80, 1'b1);
		push_byte(8'h61, 1'b0);
		push_byte(8'h62, 1'b0);
		push_byte(8'h63, 1'b1);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'h55, 1'b0);
		push_byte(8'haa, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hfe, 1'b1);
	endtask

	// lengths around the padding limit and the block edge
	task automatic test_pad_boundaries();
		send_random_message(55);
		send_random_message(56);
		send_random_message(64);
	endtask

	// random lengths, mostly short, with the odd multi-block message
	task automatic test_random_messages();
		int len;
		while (bytes_sent < RANDOM_STOP) begin
			if ($urandom_range(0, 4) != 0)
				len = $urandom_range(1, 16);
			else
				len = $urandom_range(17, 130);
			if (len > RANDOM_STOP - bytes_sent)
				len = RANDOM_STOP - bytes_sent;
			send_random_message(len);
		end
	endtask

	// a final stretch with both sides running flat out
	task automatic test_no_idle();
		wait_drained();
		idle_on = 1'b0;
		repeat (16) @(posedge clk);
		send_random_message(1);
		send_random_message(20);
		send_random_message(65);
	endtask

	// receiver stall bursts
	initial begin
		forever begin
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (idle_on) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// compare each digest word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_digest_q.size() == 0) begin
				$display("%0t: unexpected digest word, expected none, got %h last %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				if (m_tdata !== expected_digest_q[0].word ||
					m_tlast !== expected_digest_q[0].last) begin
					$display("%0t: digest word mismatch, expected %h last %b, got %h last %b",
						$time, expected_digest_q[0].word, expected_digest_q[0].last,
						m_tdata, m_tlast);
					errors++;
				end
				void'(expected_digest_q.pop_front());
				words_checked++;
			end
		end
	end

	initial begin
		int waited;
		for (int i = 0; i < 8; i++)
			chain_h[i] = SHA_H0[i];
		byte_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_messages();
		test_pad_boundaries();
		test_random_messages();
		test_no_idle();

		// let the last digest come out
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_digest_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_digest_q.size() != 0) begin
			$display("%0t: %0d digest words never arrived, expected %h last %b, got nothing",
				$time, expected_digest_q.size(), expected_digest_q[0].word,
				expected_digest_q[0].last);
			errors++;
		end

		$display("hashed %0d messages from %0d bytes, %0d digest words compared, %0d errors",
			messages_sent, bytes_sent, words_checked, errors);
		$display("lengths covered single bytes, pad limit 55/56, full blocks and multi-block runs");
		if (errors == 0)
			$display("sha256_byte_stream_hasher test passed");
		else
			$display("sha256_byte_stream_hasher test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("sha256_byte_stream_hasher test failed");
		$finish;
	end

endmodule
